@@ design/ordered_key_list_engine_unit_macros.svh @@
// Assertion macros used by the key list engine sequencer.
`ifndef ORDERED_KEY_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_KEY_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OKLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("okle assertion failed");

// Next-cycle implication, checked outside reset.
`define OKLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("okle assertion failed");

`endif

@@ design/okle_pkg.sv @@
// Types, codes and address helpers of the ordered key list engine.
package okle_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int KEY_W    = 32;

    localparam logic [2:0] ACT_INSERT    = 3'd0;
    localparam logic [2:0] ACT_DEL_KEY   = 3'd1;
    localparam logic [2:0] ACT_DEL_FIRST = 3'd2;
    localparam logic [2:0] ACT_DEL_LAST  = 3'd3;
    localparam logic [2:0] ACT_READ      = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [KEY_W-1:0] key;
        logic [4:0]              position;
    } req_t;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [KEY_W-1:0] key_out;
        logic [5:0]              count;
    } rsp_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    // Circular buffer: logical position from the front -> memory address.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] lpos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(lpos);
        if (sum >= SUM_W'(CAPACITY))
            sum = sum - SUM_W'(CAPACITY);
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] head_dec(input logic [IDX_W-1:0] head);
        return (head == '0) ? IDX_W'(CAPACITY - 1) : head - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] head_inc(input logic [IDX_W-1:0] head);
        return (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;
    endfunction

endpackage

@@ design/okle_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
module okle_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/okle_seq.sv @@
// Sequencer: head and count, key scan, compaction walk and result capture.
`include "ordered_key_list_engine_unit_macros.svh"
module okle_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  okle_pkg::req_t                   req,
    output logic                             res_valid,
    input  logic                             res_ready,
    output okle_pkg::rsp_t                   res,
    output okle_pkg::ram_req_t               ram,
    input  logic [okle_pkg::KEY_W-1:0]       rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [okle_pkg::IDX_W-1:0]    head_reg, head_next;
    logic [okle_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [okle_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [okle_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [2:0]                    status_reg, status_next;
    logic [okle_pkg::KEY_W-1:0]    key_out_reg, key_out_next;

    logic [okle_pkg::CNT_W-1:0]    idx_plus;
    logic                          at_last;
    logic                          is_empty;
    logic                          pos_ok;

    assign idx_plus = idx_reg + 1'b1;
    assign at_last  = (idx_plus == count_reg);
    assign is_empty = (count_reg == '0);
    assign pos_ok   = (32'(req.position) < 32'(count_reg))
                   && (32'(req.position) < 32'(okle_pkg::CAPACITY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        status_reg  <= status_next;
        key_out_reg <= key_out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        status_next  = status_reg;
        key_out_next = key_out_reg;
        ram          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next     = req.key;
                    status_next  = okle_pkg::ST_OK;
                    key_out_next = '0;
                    state_next   = S_DONE;
                    case (req.action)
                        okle_pkg::ACT_INSERT:
                        begin
                            if (count_reg == okle_pkg::CNT_W'(okle_pkg::CAPACITY))
                                status_next = okle_pkg::ST_FULL;
                            else
                            begin
                                head_next = okle_pkg::head_dec(head_reg);
                                ram.we    = 1'b1;
                                ram.waddr = okle_pkg::head_dec(head_reg);
                                ram.wdata = req.key;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        okle_pkg::ACT_DEL_KEY:
                        begin
                            if (is_empty)
                                status_next = okle_pkg::ST_NOT_FOUND;
                            else
                            begin
                                ram.re     = 1'b1;
                                ram.raddr  = head_reg;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        okle_pkg::ACT_DEL_FIRST:
                        begin
                            if (is_empty)
                                status_next = okle_pkg::ST_EMPTY;
                            else
                            begin
                                head_next  = okle_pkg::head_inc(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        okle_pkg::ACT_DEL_LAST:
                        begin
                            if (is_empty)
                                status_next = okle_pkg::ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        okle_pkg::ACT_READ:
                        begin
                            if (pos_ok)
                            begin
                                ram.re     = 1'b1;
                                ram.raddr  = okle_pkg::phys(head_reg,
                                                 okle_pkg::CNT_W'(req.position));
                                state_next = S_READ;
                            end
                            else
                                status_next = okle_pkg::ST_RANGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rdata holds the entry at idx_reg; fetch the next one meanwhile
                ram.re    = 1'b1;
                ram.raddr = okle_pkg::phys(head_reg, idx_plus);
                if (rdata == key_reg)
                begin
                    if (at_last)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_plus;
                        state_next = S_SHIFT;
                    end
                end
                else if (at_last)
                begin
                    status_next = okle_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                    idx_next = idx_plus;
            end
            S_SHIFT:
            begin
                // move entry idx_reg down by one, fetch idx_reg + 1
                ram.we    = 1'b1;
                ram.waddr = okle_pkg::phys(head_reg, idx_reg - 1'b1);
                ram.wdata = rdata;
                ram.re    = 1'b1;
                ram.raddr = okle_pkg::phys(head_reg, idx_plus);
                if (at_last)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                    idx_next = idx_plus;
            end
            S_READ:
            begin
                key_out_next = rdata;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.status  = status_reg;
    assign res.key_out = key_out_reg;
    assign res.count   = 6'(count_reg);

    `OKLE_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1,
        count_reg <= okle_pkg::CNT_W'(okle_pkg::CAPACITY))
    `OKLE_ASSERT_IMP(a_idx_in_list, clk, rst_n,
        (state_reg == S_SCAN) || (state_reg == S_SHIFT), idx_reg < count_reg)
    `OKLE_ASSERT_IMP(a_write_states, clk, rst_n, ram.we,
        (state_reg == S_IDLE) || (state_reg == S_SHIFT))
    `OKLE_ASSERT_IMP(a_shift_no_overlap, clk, rst_n, state_reg == S_SHIFT,
        ram.waddr != ram.raddr)
    `OKLE_ASSERT_NXT(a_miss_reported, clk, rst_n,
        (state_reg == S_SCAN) && (rdata != key_reg) && at_last,
        status_reg == okle_pkg::ST_NOT_FOUND)

endmodule

@@ design/ordered_key_list_engine_unit.sv @@
// Top level of the ordered key list engine: sequencer, entry RAM, result register.
//
//   channel  | handshake             | beat
//   ---------+-----------------------+-------------------------------
//   request  | req_valid / req_ready | req: action, key, position
//   response | rsp_valid / rsp_ready | rsp: status, key_out, count
//
// Actions other than delete by key finish without a RAM walk; a read in range also passes a RAM read state.
// Delete by key walks the entry RAM one entry per cycle (single read port),
// scan and compaction together in one pass.
// Reset clears head, count and control; RAM contents are not cleared.
// A finished beat waits in the response register; the next request is taken meanwhile.
module ordered_key_list_engine_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  okle_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output okle_pkg::rsp_t   rsp
);

    okle_pkg::ram_req_t         ram;
    logic [okle_pkg::KEY_W-1:0] rdata;
    logic                       res_valid;
    logic                       res_ready;
    okle_pkg::rsp_t             res;

    logic                       rsp_valid_reg;
    okle_pkg::rsp_t             rsp_reg;

    okle_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram       (ram),
        .rdata     (rdata)
    );

    okle_ram #(
        .DEPTH (okle_pkg::CAPACITY),
        .WIDTH (okle_pkg::KEY_W),
        .AW    (okle_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/key_list_checker.sv @@
`timescale 1ns / 100ps
// Key list checker: keeps its own copy of the list, predicts each response and compares.
module key_list_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  okle_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  okle_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending,
    output int             rsp_total,
    output logic [7:0]     status_hits
);
    import okle_pkg::*;

    logic [KEY_W-1:0] list_keys [CAPACITY];
    logic [5:0]       list_len;
    rsp_t             due_rsps [$];
    rsp_t             want;

    task automatic flag_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        $display("%0t ns: mismatch in %s: expected %h, got %h", $time, what, exp_val, got_val);
        fail_count = fail_count + 1;
    endtask

    // Close the gap left at idx; later entries move one toward the front.
    function automatic void drop_entry(input int idx);
        int i;
        for (i = idx; i + 1 < list_len; i++)
            list_keys[i] = list_keys[i + 1];
        list_len = list_len - 1'b1;
    endfunction

    function automatic rsp_t apply_to_list(input req_t beat);
        rsp_t res;
        int   i;
        int   hit;
        res.status  = ST_OK;
        res.key_out = '0;
        hit = -1;
        case (beat.action)
            ACT_INSERT:
            begin
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (i = int'(list_len); i > 0; i--)
                        list_keys[i] = list_keys[i - 1];
                    list_keys[0] = beat.key;
                    list_len = list_len + 1'b1;
                end
            end
            ACT_DEL_KEY:
            begin
                for (i = 0; i < list_len; i++)
                    if (hit < 0 && list_keys[i] == beat.key)
                        hit = i;
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                    drop_entry(hit);
            end
            ACT_DEL_FIRST:
            begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    drop_entry(0);
            end
            ACT_DEL_LAST:
            begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    list_len = list_len - 1'b1;
            end
            ACT_READ:
            begin
                if (beat.position < list_len)
                    res.key_out = list_keys[beat.position];
                else
                    res.status = ST_RANGE;
            end
            default:
            begin
                // spare action codes leave the list alone
            end
        endcase
        res.count = list_len;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_rsps.delete();
            list_len    = '0;
            fail_count  = 0;
            pending     <= 0;
            rsp_total   <= 0;
            status_hits <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                due_rsps.push_back(apply_to_list(req));
            if (rsp_valid && rsp_ready)
            begin
                rsp_total <= rsp_total + 1;
                status_hits[rsp.status] <= 1'b1;
                if (due_rsps.size() == 0)
                    flag_mismatch("response with none due (status)", '0, 32'(rsp.status));
                else
                begin
                    want = due_rsps.pop_front();
                    if (rsp.status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(rsp.status));
                    if (rsp.key_out !== want.key_out)
                        flag_mismatch("key_out", want.key_out, rsp.key_out);
                    if (rsp.count !== want.count)
                        flag_mismatch("count", 32'(want.count), 32'(rsp.count));
                end
            end
            pending <= due_rsps.size();
        end
    end

endmodule

@@ tb/ordered_key_list_engine_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and response traffic, watchdog and verdict.
module ordered_key_list_engine_unit_test;
    import okle_pkg::*;

    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    // any other mode is the mixed one
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;

    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 100;
    localparam int QUIET_PHASES  = 2;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 48;

    logic       clk       = 1'b0;
    logic       rst_n;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;

    int         fail_count;
    int         pending;
    int         rsp_total;
    logic [7:0] status_hits;

    int         items_sent     = 0;
    int         req_idle_odds  = 0;
    int         rsp_idle_odds  = 0;
    int         rsp_stall_left = 0;
    int         quiet_cycles   = 0;

    ordered_key_list_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    key_list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .pending     (pending),
        .rsp_total   (rsp_total),
        .status_hits (status_hits)
    );

    always #10 clk = ~clk;

    // Response side: ready drops in random bursts when idling is on.
    always @(posedge clk)
    begin
        if (rsp_stall_left > 0)
        begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ready      <= 1'b0;
        end
        else if (rsp_idle_odds != 0 && $urandom_range(0, rsp_idle_odds) == 0)
        begin
            rsp_stall_left <= $urandom_range(0, 12);
            rsp_ready      <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("ordered_key_list_engine_unit_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic [2:0] act, input logic [31:0] key_val,
                             input logic [4:0] pos);
        req_t beat;
        int   gap;
        beat.action   = act;
        beat.key      = key_val;
        beat.position = pos;
        req       <= beat;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        items_sent++;
        if (req_idle_odds != 0 && $urandom_range(0, req_idle_odds) == 0)
        begin
            gap = $urandom_range(1, 13);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [2:0] pick_action(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll >= 95)
        begin
            case ($urandom_range(0, 2))
                0:       return ACT_SPARE_A;
                1:       return ACT_SPARE_B;
                default: return ACT_SPARE_C;
            endcase
        end
        case (mode)
            MODE_GROW:
                if (roll < 65)      return ACT_INSERT;
                else if (roll < 75) return ACT_DEL_KEY;
                else if (roll < 80) return ACT_DEL_FIRST;
                else if (roll < 85) return ACT_DEL_LAST;
                else                return ACT_READ;
            MODE_SHRINK:
                if (roll < 12)      return ACT_INSERT;
                else if (roll < 32) return ACT_DEL_KEY;
                else if (roll < 57) return ACT_DEL_FIRST;
                else if (roll < 82) return ACT_DEL_LAST;
                else                return ACT_READ;
            default:
                if (roll < 35)      return ACT_INSERT;
                else if (roll < 50) return ACT_DEL_KEY;
                else if (roll < 62) return ACT_DEL_FIRST;
                else if (roll < 74) return ACT_DEL_LAST;
                else                return ACT_READ;
        endcase
    endfunction

    // Mostly a small pool so deletes by key hit and duplicates occur.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [4:0] pick_position();
        if ($urandom_range(0, 1) == 0)
            return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-list corners, spare codes, extreme keys, duplicates
        send_item(ACT_DEL_FIRST, 32'h0, 5'd0);
        send_item(ACT_DEL_LAST,  32'h0, 5'd0);
        send_item(ACT_DEL_KEY,   32'h0, 5'd0);
        send_item(ACT_READ,      32'h0, 5'd0);
        send_item(ACT_READ,      32'h0, 5'd31);
        send_item(ACT_SPARE_A,   32'hFFFF_FFFF, 5'd31);
        send_item(ACT_SPARE_B,   32'h1234_5678, 5'd3);
        send_item(ACT_SPARE_C,   32'h8000_0000, 5'd0);
        send_item(ACT_INSERT,    32'h7FFF_FFFF, 5'd0);
        send_item(ACT_INSERT,    32'h8000_0000, 5'd31);
        send_item(ACT_INSERT,    32'h0000_0000, 5'd0);
        send_item(ACT_INSERT,    32'hFFFF_FFFF, 5'd0);
        send_item(ACT_INSERT,    32'h8000_0000, 5'd0);
        send_item(ACT_READ,      32'h0, 5'd0);
        send_item(ACT_READ,      32'h0, 5'd4);
        send_item(ACT_READ,      32'h0, 5'd5);
        send_item(ACT_DEL_KEY,   32'h8000_0000, 5'd0);
        send_item(ACT_DEL_KEY,   32'h1234_5678, 5'd0);
        send_item(ACT_READ,      32'h0, 5'd2);
        send_item(ACT_DEL_FIRST, 32'h0, 5'd0);
        send_item(ACT_DEL_LAST,  32'h0, 5'd0);
        send_item(ACT_READ,      32'h0, 5'd1);
        send_item(ACT_DEL_KEY,   32'h0000_0000, 5'd0);
        send_item(ACT_DEL_KEY,   32'h8000_0000, 5'd0);
        send_item(ACT_DEL_LAST,  32'h0, 5'd0);
        wait_for_drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase >= PHASES - QUIET_PHASES)
            begin
                req_idle_odds <= 0;
                rsp_idle_odds <= 0;
            end
            else
            begin
                req_idle_odds <= $urandom_range(0, 2) * 4;
                rsp_idle_odds <= $urandom_range(0, 2) * 4;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_action(phase % 3), pick_key(), pick_position());
            // hold the sender off until every response is back
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests, %0d responses, in grow, shrink and mixed phases.",
                 items_sent, rsp_total);
        $display("Status seen: ok %0b, not found %0b, full %0b, empty %0b, range %0b.",
                 status_hits[ST_OK], status_hits[ST_NOT_FOUND], status_hits[ST_FULL],
                 status_hits[ST_EMPTY], status_hits[ST_RANGE]);
        if (fail_count == 0 && pending == 0)
            $display("ordered_key_list_engine_unit_test: PASS");
        else
            $display("ordered_key_list_engine_unit_test: FAIL");
        $finish;
    end

endmodule
